### rtl/core/spiral_matrix_reader_macros.svh
// Assertion macros shared by the RTL of the spiral matrix reader.
// Each macro takes a label, the clock, the active-low reset and two expressions.
// With NO_ASSERTIONS defined they expand to nothing.
`ifndef SPIRAL_MATRIX_READER_MACROS_SVH
`define SPIRAL_MATRIX_READER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spiral matrix reader: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spiral matrix reader: next-cycle check failed");

`else

`define SMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/smr_pkg.sv
package smr_pkg;

	// Fixed field widths of the two channels.
	localparam int ELEM_W    = 32;
	localparam int IDX_OUT_W = 4;

	// Configuration register width and the widths of the walk state.
	localparam int CNT_W = 5;
	localparam int LP_W  = 9;
	localparam int BND_W = CNT_W + 1;
	localparam int CUR_W = CNT_W;

	// Load position divider: one quotient bit per cycle.
	localparam int DIV_STEPS = LP_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int DEF_MAX_ROWS    = 16;
	localparam int DEF_MAX_COLUMNS = 16;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam logic [CNT_W-1:0] RESET_ROW_COUNT    = CNT_W'(4);
	localparam logic [CNT_W-1:0] RESET_COLUMN_COUNT = CNT_W'(4);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} op_t;

	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef struct packed {
		op_t                      op;
		logic signed [ELEM_W-1:0] element_in;
	} in_item_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element_out;
		logic [IDX_OUT_W-1:0]     out_row;
		logic [IDX_OUT_W-1:0]     out_column;
		logic                     final_flag;
	} out_item_t;

endpackage

### rtl/core/spiral_matrix_reader.sv
// Channel   Handshake                 Payload                     Direction
// item      item_valid / item_stall   item (in_item_t)            into the block
// result    result_valid / result_stall result (out_item_t)       out of the block
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data         into the block
//
// One transaction is taken in every cycle while item_stall is low; an emit's result
// comes in the next cycle from the memory's registered read port, the output register.
// A write to column_count starts a restoring division of the load position,
// during which item_stall and !cfg_ready are held; other writes cost nothing.
// Reset clears all control state; the matrix store itself is not cleared.
// A held result_stall stalls the item channel only while a result is waiting.
`include "spiral_matrix_reader_macros.svh"

module spiral_matrix_reader
	import smr_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             item_valid,
	output logic             item_stall,
	input  in_item_t         item,

	output logic             result_valid,
	input  logic             result_stall,
	output out_item_t        result,

	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_reg_t         cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	// The store holds at most 32 bits of each element, since only those are ever delivered.
	localparam int STORE_W = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;
	localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers.
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] column_count_q;

	// Effective counts: zero acts as one, anything above the maximum acts as the maximum.
	logic [CNT_W-1:0] rows_eff;
	logic [CNT_W-1:0] cols_eff;

	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = CNT_W'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_eff = CNT_W'(MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
		if (column_count_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (int'(column_count_q) > MAX_COLUMNS) begin
			cols_eff = CNT_W'(MAX_COLUMNS);
		end else begin
			cols_eff = column_count_q;
		end
	end

	// Load side: the linear position and its row and column under the current column count.
	// Outside a division, position = row * columns + column with column below columns.
	logic [LP_W-1:0]  load_pos_q;
	logic [LP_W-1:0]  load_row_q;
	logic [CUR_W-1:0] load_col_q;

	// Divider that re-derives the row and column once the column count has been rewritten.
	logic                 div_busy_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LP_W-1:0]      div_quo_q;
	logic [CUR_W-1:0]     div_rem_q;
	logic [CUR_W:0]       div_trial;
	logic                 div_take;
	logic [LP_W-1:0]      div_quo_next;
	logic [CUR_W-1:0]     div_rem_next;
	logic                 div_last;

	// Spiral walk state.
	logic signed [BND_W-1:0] top_q, bottom_q, left_q, right_q;
	dir_t                    dir_q;
	logic [CUR_W-1:0]        cur_row_q, cur_col_q;
	logic [LP_W-1:0]         emitted_q;
	logic                    done_q;

	// Output stage.
	logic                    out_valid_q;
	logic [STORE_W-1:0]      rd_q;
	logic [IDX_OUT_W-1:0]    out_row_q;
	logic [IDX_OUT_W-1:0]    out_col_q;
	logic                    out_final_q;

	logic [STORE_W-1:0]      mem [DEPTH];

	// Handshakes.
	logic item_accept;
	logic load_fire;
	logic emit_fire;
	logic cfg_fire;

	assign item_stall   = div_busy_q | (out_valid_q & result_stall);
	assign item_accept  = item_valid & ~item_stall;
	assign load_fire    = item_accept & (item.op == OP_LOAD);
	assign emit_fire    = item_accept & (item.op == OP_EMIT) & ~done_q;
	assign cfg_ready    = ~div_busy_q;
	assign cfg_fire     = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= RESET_ROW_COUNT;
			column_count_q <= RESET_COLUMN_COUNT;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Restoring division, most significant quotient bit first. The divisor is read
	// from the register, which already holds the new count when the division starts.
	always_comb begin
		div_trial    = {div_rem_q, div_quo_q[LP_W-1]};
		div_take     = (div_trial >= {1'b0, cols_eff});
		div_rem_next = div_take ? CUR_W'(div_trial - {1'b0, cols_eff}) : CUR_W'(div_trial);
		div_quo_next = {div_quo_q[LP_W-2:0], div_take};
		div_last     = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cfg_fire && (cfg_index == REG_COLUMN_COUNT)) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (div_last) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_fire && (cfg_index == REG_COLUMN_COUNT)) begin
			div_quo_q <= load_pos_q;
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			div_quo_q <= div_quo_next;
			div_rem_q <= div_rem_next;
		end
	end

	// Load path. A load after the spiral has finished starts a fresh matrix at position zero.
	logic [LP_W-1:0]   lp_eff;
	logic [LP_W-1:0]   lr_eff;
	logic [CUR_W-1:0]  lc_eff;
	logic [LP_W-1:0]   lp_inc;
	logic [CUR_W-1:0]  lc_inc;
	logic              store;
	logic [ADDR_W-1:0] wr_addr;

	always_comb begin
		lp_eff  = done_q ? '0 : load_pos_q;
		lr_eff  = done_q ? '0 : load_row_q;
		lc_eff  = done_q ? '0 : load_col_q;
		lp_inc  = lp_eff + LP_W'(1);
		lc_inc  = lc_eff + CUR_W'(1);
		// position < rows * columns exactly when its row is below the row count
		store   = load_fire & (lr_eff < LP_W'(rows_eff));
		wr_addr = ADDR_W'(int'(lr_eff) * MAX_COLUMNS + int'(lc_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (div_busy_q && div_last) begin
			load_row_q <= div_quo_next;
			load_col_q <= div_rem_next;
		end else if (store) begin
			load_pos_q <= lp_inc;
			if (lp_inc == '0) begin
				// the nine-bit position wraps, and so do its row and column
				load_row_q <= '0;
				load_col_q <= '0;
			end else if (lc_inc == cols_eff) begin
				load_row_q <= lr_eff + LP_W'(1);
				load_col_q <= '0;
			end else begin
				load_row_q <= lr_eff;
				load_col_q <= lc_inc;
			end
		end else if (load_fire) begin
			load_pos_q <= lp_eff;
			load_row_q <= lr_eff;
			load_col_q <= lc_eff;
		end
	end

	// Emit path. The first emit of a spiral (emitted count at zero) latches the bounds
	// from the current counts; after that the latched bounds stay in force.
	logic                    start;
	logic signed [BND_W-1:0] top_c, bottom_c, left_c, right_c;
	dir_t                    dir_c;
	logic [CUR_W-1:0]        row_c, col_c;
	logic signed [BND_W-1:0] top_n, bottom_n, left_n, right_n;
	dir_t                    dir_n;
	logic [CUR_W-1:0]        row_n, col_n;
	logic                    done_n;
	logic signed [BND_W-1:0] row_s, col_s;
	logic [ADDR_W-1:0]       rd_addr;

	always_comb begin
		start    = (emitted_q == '0);
		top_c    = start ? '0 : top_q;
		left_c   = start ? '0 : left_q;
		bottom_c = start ? ($signed({1'b0, rows_eff}) - BND_W'(1)) : bottom_q;
		right_c  = start ? ($signed({1'b0, cols_eff}) - BND_W'(1)) : right_q;
		dir_c    = start ? DIR_RIGHT : dir_q;
		row_c    = start ? '0 : cur_row_q;
		col_c    = start ? '0 : cur_col_q;
		rd_addr  = ADDR_W'(int'(row_c) * MAX_COLUMNS + int'(col_c));

		row_s    = $signed({1'b0, row_c});
		col_s    = $signed({1'b0, col_c});
		top_n    = top_c;
		bottom_n = bottom_c;
		left_n   = left_c;
		right_n  = right_c;
		dir_n    = dir_c;
		row_n    = row_c;
		col_n    = col_c;
		done_n   = 1'b0;

		// Step the cursor; at the end of a side the bound behind it closes in and the
		// walk turns, unless the ring has run out, which ends the spiral.
		case (dir_c)
			DIR_RIGHT: begin
				if (col_s < right_c) begin
					col_n = col_c + CUR_W'(1);
				end else begin
					top_n = top_c + BND_W'(1);
					if (top_n > bottom_c) begin
						done_n = 1'b1;
					end else begin
						dir_n = DIR_DOWN;
						row_n = CUR_W'(top_n);
					end
				end
			end
			DIR_DOWN: begin
				if (row_s < bottom_c) begin
					row_n = row_c + CUR_W'(1);
				end else begin
					right_n = right_c - BND_W'(1);
					if (left_c > right_n) begin
						done_n = 1'b1;
					end else begin
						dir_n = DIR_LEFT;
						col_n = CUR_W'(right_n);
					end
				end
			end
			DIR_LEFT: begin
				if (col_s > left_c) begin
					col_n = col_c - CUR_W'(1);
				end else begin
					bottom_n = bottom_c - BND_W'(1);
					if (top_c > bottom_n) begin
						done_n = 1'b1;
					end else begin
						dir_n = DIR_UP;
						row_n = CUR_W'(bottom_n);
					end
				end
			end
			DIR_UP: begin
				if (row_s > top_c) begin
					row_n = row_c - CUR_W'(1);
				end else begin
					left_n = left_c + BND_W'(1);
					if (left_n > right_c) begin
						done_n = 1'b1;
					end else begin
						dir_n = DIR_RIGHT;
						col_n = CUR_W'(left_n);
						row_n = CUR_W'(top_c);
					end
				end
			end
			default: begin
				done_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			bottom_q  <= '0;
			left_q    <= '0;
			right_q   <= '0;
			dir_q     <= DIR_RIGHT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			emitted_q <= '0;
			done_q    <= 1'b0;
		end else if (emit_fire) begin
			top_q     <= top_n;
			bottom_q  <= bottom_n;
			left_q    <= left_n;
			right_q   <= right_n;
			dir_q     <= dir_n;
			cur_row_q <= row_n;
			cur_col_q <= col_n;
			emitted_q <= emitted_q + LP_W'(1);
			done_q    <= done_n;
		end else if (load_fire && done_q) begin
			emitted_q <= '0;
			done_q    <= 1'b0;
		end
	end

	// Matrix store: one write port for loads, one registered read port for emits.
	always_ff @(posedge clk) begin
		if (store) begin
			mem[wr_addr] <= item.element_in[STORE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			rd_q        <= mem[rd_addr];
			out_row_q   <= IDX_OUT_W'(row_c);
			out_col_q   <= IDX_OUT_W'(col_c);
			out_final_q <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid       = out_valid_q;
	assign result.element_out = ELEM_W'(rd_q);
	assign result.out_row     = out_row_q;
	assign result.out_column  = out_col_q;
	assign result.final_flag  = out_final_q;

	// An emit that walks the spiral always leaves a result behind it.
	`SMR_ASSERT_NEXT(a_emit_gives_result, clk, arst_n, emit_fire, out_valid_q)

	// Outside a division the load column stays below the column count.
	`SMR_ASSERT_IMPLY(a_load_col_range, clk, arst_n, !div_busy_q, load_col_q < cols_eff)

	// Part-way through a spiral the cursor lies inside the current ring.
	`SMR_ASSERT_IMPLY(a_cursor_in_ring, clk, arst_n, !done_q && (emitted_q != '0),
		($signed({1'b0, cur_row_q}) >= top_q) && ($signed({1'b0, cur_row_q}) <= bottom_q) &&
		($signed({1'b0, cur_col_q}) >= left_q) && ($signed({1'b0, cur_col_q}) <= right_q))

endmodule

### sim/tb_spiral_matrix_reader.sv
module tb_spiral_matrix_reader;
	timeunit 1ns;
	timeprecision 1ps;

	import smr_pkg::*;

	// Geometry of the store as the block is built here.
	localparam int GRID_ROWS  = DEF_MAX_ROWS;
	localparam int GRID_COLS  = DEF_MAX_COLUMNS;
	localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

	// Number of state-changing transactions after which the stimulus stops.
	localparam int ITEM_TARGET = 1100;

	// Rows of the opening script are either a register write or an item transaction.
	typedef enum logic {
		ROW_CONFIG,
		ROW_TRANSACTION
	} row_kind_t;

	// How the result of an item row is checked: against the shadow walk, against a
	// value typed into the script, or not at all because no result may come.
	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_TYPED,
		CHECK_NONE
	} check_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_reg_t         sel;
		logic [CNT_W-1:0] value;
		in_item_t         stim;
		check_t           check;
		out_item_t        typed;
	} script_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	in_item_t         item;
	logic             result_valid;
	logic             result_stall;
	out_item_t        result;
	logic             cfg_valid;
	logic             cfg_ready;
	cfg_reg_t         cfg_index;
	logic [CNT_W-1:0] cfg_data;

	spiral_matrix_reader u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow copy of the block: the matrix, which cells hold a loaded value, the two
	// count registers as written, and the walk state of the spiral.
	logic signed [ELEM_W-1:0] shadow_cells [GRID_CELLS];
	bit                       cell_loaded  [GRID_CELLS];
	logic [CNT_W-1:0]         shadow_rows;
	logic [CNT_W-1:0]         shadow_cols;
	logic [LP_W-1:0]          fill_pos;
	logic [LP_W-1:0]          emit_count;
	int                       top_b;
	int                       bottom_b;
	int                       left_b;
	int                       right_b;
	int                       cur_r;
	int                       cur_c;
	dir_t                     walk_dir;
	bit                       walk_done;

	// Spiral elements still owed by the block, oldest first.
	out_item_t   pending_results [$];
	script_row_t opening_script [$];

	int mismatches      = 0;
	int effective_items = 0;
	bit smooth_sender   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A count of zero behaves as one and anything above the store's size as the size.
	function automatic int rows_in_use();
		if (shadow_rows == 0)
			return 1;
		return (shadow_rows > GRID_ROWS) ? GRID_ROWS : int'(shadow_rows);
	endfunction

	function automatic int cols_in_use();
		if (shadow_cols == 0)
			return 1;
		return (shadow_cols > GRID_COLS) ? GRID_COLS : int'(shadow_cols);
	endfunction

	// Moves the cursor one step clockwise. Reaching the end of a side pulls that
	// side's bound inwards; bounds that cross mean the spiral is complete, which is
	// also what stops a single row or column from being walked twice.
	function automatic void step_cursor();
		case (walk_dir)
			DIR_RIGHT: begin
				if (cur_c < right_b) begin
					cur_c++;
				end else begin
					top_b++;
					if (top_b > bottom_b) begin
						walk_done = 1'b1;
					end else begin
						walk_dir = DIR_DOWN;
						cur_r    = top_b;
					end
				end
			end
			DIR_DOWN: begin
				if (cur_r < bottom_b) begin
					cur_r++;
				end else begin
					right_b--;
					if (left_b > right_b) begin
						walk_done = 1'b1;
					end else begin
						walk_dir = DIR_LEFT;
						cur_c    = right_b;
					end
				end
			end
			DIR_LEFT: begin
				if (cur_c > left_b) begin
					cur_c--;
				end else begin
					bottom_b--;
					if (top_b > bottom_b) begin
						walk_done = 1'b1;
					end else begin
						walk_dir = DIR_UP;
						cur_r    = bottom_b;
					end
				end
			end
			default: begin
				if (cur_r > top_b) begin
					cur_r--;
				end else begin
					left_b++;
					if (left_b > right_b) begin
						walk_done = 1'b1;
					end else begin
						walk_dir = DIR_RIGHT;
						cur_c    = left_b;
						cur_r    = top_b;
					end
				end
			end
		endcase
	endfunction

	// Applies one accepted transaction to the shadow state. Returns one when the
	// transaction yields a spiral element, which is then placed in res.
	function automatic bit spiral_walk_predict(input in_item_t it, output out_item_t res);
		int rows;
		int cols;
		int spot;
		rows = rows_in_use();
		cols = cols_in_use();
		res  = '0;
		if (it.op == OP_LOAD) begin
			// A load after the spiral has finished begins a fresh matrix.
			if (walk_done) begin
				fill_pos   = '0;
				emit_count = '0;
				walk_done  = 1'b0;
			end
			if (int'(fill_pos) < rows * cols) begin
				spot = (int'(fill_pos) / cols) * GRID_COLS + int'(fill_pos) % cols;
				shadow_cells[spot] = it.element_in;
				cell_loaded[spot]  = 1'b1;
				fill_pos           = fill_pos + 1'b1;
				effective_items++;
			end
			return 1'b0;
		end
		if (walk_done)
			return 1'b0;
		// The first request of a spiral latches the bounds from the registers.
		if (emit_count == 0) begin
			top_b    = 0;
			left_b   = 0;
			bottom_b = rows - 1;
			right_b  = cols - 1;
			walk_dir = DIR_RIGHT;
			cur_r    = 0;
			cur_c    = 0;
		end
		spot            = cur_r * GRID_COLS + cur_c;
		res.element_out = shadow_cells[spot];
		res.out_row     = IDX_OUT_W'(cur_r);
		res.out_column  = IDX_OUT_W'(cur_c);
		step_cursor();
		emit_count     = emit_count + 1'b1;
		res.final_flag = walk_done;
		effective_items++;
		return 1'b1;
	endfunction

	// An emit is only offered when the cell that it reads has been loaded at some point.
	function automatic bit emit_is_safe();
		if (walk_done)
			return 1'b1;
		if (emit_count == 0)
			return cell_loaded[0];
		return cell_loaded[cur_r * GRID_COLS + cur_c];
	endfunction

	function automatic logic signed [ELEM_W-1:0] random_element();
		case ($urandom_range(0, 11))
			0:       return {1'b0, {(ELEM_W-1){1'b1}}};
			1:       return {1'b1, {(ELEM_W-1){1'b0}}};
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly small matrices, with zero, the maximum and values beyond it now and then.
	function automatic logic [CNT_W-1:0] random_count();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return CNT_W'(GRID_ROWS);
			2:       return '1;
			3:       return CNT_W'($urandom_range(GRID_ROWS + 1, 30));
			default: return CNT_W'($urandom_range(1, 6));
		endcase
	endfunction

	// Picks the next transaction from the walk state, so that most traffic forms whole
	// matrices: loads until the matrix is full, emits mixed in, then emits to the end.
	// Emits after completion and loads into a full matrix are the noise.
	function automatic in_item_t random_transaction();
		in_item_t it;
		int       cap;
		int       roll;
		cap  = rows_in_use() * cols_in_use();
		roll = $urandom_range(0, 99);
		if (walk_done)
			it.op = (roll < 85) ? OP_LOAD : OP_EMIT;
		else if (int'(fill_pos) < cap)
			it.op = (roll < 55) ? OP_LOAD : OP_EMIT;
		else
			it.op = (roll < 8) ? OP_LOAD : OP_EMIT;
		if (it.op == OP_EMIT && !emit_is_safe())
			it.op = OP_LOAD;
		it.element_in = random_element();
		return it;
	endfunction

	function automatic void script_cfg(input cfg_reg_t sel, input logic [CNT_W-1:0] value);
		script_row_t r;
		r       = '0;
		r.kind  = ROW_CONFIG;
		r.sel   = sel;
		r.value = value;
		opening_script.push_back(r);
	endfunction

	function automatic void script_load(input logic [ELEM_W-1:0] value);
		script_row_t r;
		r                 = '0;
		r.kind            = ROW_TRANSACTION;
		r.stim.op         = OP_LOAD;
		r.stim.element_in = value;
		r.check           = CHECK_MODEL;
		opening_script.push_back(r);
	endfunction

	function automatic void script_emit(input check_t check, input logic [ELEM_W-1:0] value,
			input int row, input int col, input bit fin);
		script_row_t r;
		r                  = '0;
		r.kind             = ROW_TRANSACTION;
		r.stim.op          = OP_EMIT;
		r.stim.element_in  = $urandom;
		r.check            = check;
		r.typed.element_out = value;
		r.typed.out_row    = IDX_OUT_W'(row);
		r.typed.out_column = IDX_OUT_W'(col);
		r.typed.final_flag = fin;
		opening_script.push_back(r);
	endfunction

	task automatic note_mismatch(input string what, input logic [ELEM_W-1:0] seen,
			input logic [ELEM_W-1:0] wanted);
		mismatches++;
		$display("%0t: mismatch on %s, saw %0h, expected %0h", $time, what, seen, wanted);
	endtask

	// Offers one item transaction after a random gap. The valid is only lowered when a
	// gap is taken, so back-to-back items keep it high. The shadow walk is advanced at
	// the edge where the block accepts the transaction.
	task automatic offer_item(input in_item_t it, input check_t check, input out_item_t typed);
		int        gap;
		out_item_t predicted;
		bit        produces;
		gap = smooth_sender ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		produces = spiral_walk_predict(it, predicted);
		case (check)
			CHECK_MODEL: begin
				if (produces)
					pending_results.push_back(predicted);
			end
			CHECK_TYPED: begin
				pending_results.push_back(typed);
			end
			default: begin
			end
		endcase
	endtask

	// Register writes happen only once every owed element has arrived and a further
	// wait has passed, so that the block is idle. A column write starts the
	// block's internal division, which simply shows up as a long wait for ready.
	task automatic write_register(input cfg_reg_t sel, input logic [CNT_W-1:0] value);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_index <= sel;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (sel == REG_ROW_COUNT)
			shadow_rows = value;
		else
			shadow_cols = value;
	endtask

	// Result side. Each accepted transaction is compared with the oldest owed element,
	// then a stall of random length, or none in smooth running, is drawn for the next
	// one. Every eighty results the sink toggles between choppy and smooth running.
	// Once, after three hundred results, it holds off so that the block fills up and
	// pushes back on the item channel while the sender keeps offering.
	initial begin : result_sink
		int        hold;
		int        accepted;
		bit        smooth;
		bit        squeezed;
		out_item_t want;
		hold     = 0;
		accepted = 0;
		smooth   = 1'b0;
		squeezed = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (pending_results.size() == 0) begin
					note_mismatch("result with nothing owed", result.element_out, '0);
				end else begin
					want = pending_results.pop_front();
					if (result.element_out !== want.element_out)
						note_mismatch("element_out", result.element_out, want.element_out);
					if (result.out_row !== want.out_row)
						note_mismatch("out_row", ELEM_W'(result.out_row),
							ELEM_W'(want.out_row));
					if (result.out_column !== want.out_column)
						note_mismatch("out_column", ELEM_W'(result.out_column),
							ELEM_W'(want.out_column));
					if (result.final_flag !== want.final_flag)
						note_mismatch("final_flag", ELEM_W'(result.final_flag),
							ELEM_W'(want.final_flag));
				end
				accepted++;
				if (accepted % 80 == 0)
					smooth = !smooth;
				if (!squeezed && accepted == 300) begin
					squeezed = 1'b1;
					hold     = 200;
				end else begin
					hold = smooth ? 0 : $urandom_range(0, 7);
				end
			end else if (hold > 0) begin
				hold--;
			end
			result_stall <= (hold > 0);
		end
	end

	initial begin : stimulus
		int          drain;
		int          phase_len;
		script_row_t row;

		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_ROW_COUNT;
		cfg_data   <= '0;

		// Shadow state after reset; the matrix itself starts out unloaded.
		foreach (cell_loaded[i]) begin
			cell_loaded[i]  = 1'b0;
			shadow_cells[i] = '0;
		end
		shadow_rows = RESET_ROW_COUNT;
		shadow_cols = RESET_COLUMN_COUNT;
		fill_pos    = '0;
		emit_count  = '0;
		top_b       = 0;
		bottom_b    = 0;
		left_b      = 0;
		right_b     = 0;
		cur_r       = 0;
		cur_c       = 0;
		walk_dir    = DIR_RIGHT;
		walk_done   = 1'b0;

		// Opening script. A single row of the reset column count, loaded with the
		// extreme values, shows the reset width and the final flag on its fourth
		// element; one more emit after completion must give nothing.
		script_cfg(REG_ROW_COUNT, CNT_W'(1));
		script_load(32'h7FFF_FFFF);
		script_load(32'h8000_0000);
		script_load(32'hFFFF_FFFF);
		script_load(32'h0000_0000);
		script_emit(CHECK_TYPED, 32'h7FFF_FFFF, 0, 0, 1'b0);
		script_emit(CHECK_TYPED, 32'h8000_0000, 0, 1, 1'b0);
		script_emit(CHECK_TYPED, 32'hFFFF_FFFF, 0, 2, 1'b0);
		script_emit(CHECK_TYPED, 32'h0000_0000, 0, 3, 1'b1);
		script_emit(CHECK_NONE, '0, 0, 0, 1'b0);
		// A load after completion restarts the matrix. A column count of zero acts as
		// one, giving a two-by-one column that is walked once; the load into the full
		// column is dropped.
		script_load(32'h5A5A_A5A5);
		script_cfg(REG_ROW_COUNT, CNT_W'(2));
		script_cfg(REG_COLUMN_COUNT, '0);
		script_load(32'hA5A5_5A5A);
		script_load(32'h1111_1111);
		script_emit(CHECK_TYPED, 32'h5A5A_A5A5, 0, 0, 1'b0);
		script_emit(CHECK_TYPED, 32'hA5A5_5A5A, 1, 0, 1'b1);
		// A two-by-two matrix, with its last element loaded while the walk is under
		// way, and the registers changed in the middle of the spiral: the latched
		// bounds must stay in force. The load after the change lands elsewhere.
		script_cfg(REG_ROW_COUNT, CNT_W'(2));
		script_cfg(REG_COLUMN_COUNT, CNT_W'(2));
		script_load(32'h0000_0001);
		script_load(32'h0000_0002);
		script_load(32'h0000_0003);
		script_emit(CHECK_MODEL, '0, 0, 0, 1'b0);
		script_load(32'h0000_0004);
		script_cfg(REG_ROW_COUNT, '1);
		script_cfg(REG_COLUMN_COUNT, CNT_W'(1));
		script_load(32'h7777_7777);
		script_emit(CHECK_TYPED, 32'h0000_0002, 0, 1, 1'b0);
		script_emit(CHECK_TYPED, 32'h0000_0004, 1, 1, 1'b0);
		script_emit(CHECK_TYPED, 32'h0000_0003, 1, 0, 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (opening_script[i]) begin
			row = opening_script[i];
			if (row.kind == ROW_CONFIG)
				write_register(row.sel, row.value);
			else
				offer_item(row.stim, row.check, row.typed);
		end

		// One full sixteen-by-sixteen matrix. Emits are only mixed in where the cell
		// has been loaded, and by the end every cell of the store has been written,
		// so that every later read sees a defined value.
		write_register(REG_ROW_COUNT, CNT_W'(GRID_ROWS));
		write_register(REG_COLUMN_COUNT, CNT_W'(GRID_COLS));
		do begin
			offer_item(random_transaction(), CHECK_MODEL, '0);
		end while (!(walk_done && int'(fill_pos) == GRID_CELLS));

		// Random phases: new counts (sometimes only one of them), then a run of
		// transactions. A phase may end in the middle of a spiral, so the counts
		// often change while the bounds are latched.
		while (effective_items < ITEM_TARGET) begin
			if ($urandom_range(0, 3) != 0)
				write_register(REG_ROW_COUNT, random_count());
			if ($urandom_range(0, 3) != 0)
				write_register(REG_COLUMN_COUNT, random_count());
			smooth_sender = ($urandom_range(0, 4) == 0);
			phase_len     = $urandom_range(15, 90);
			repeat (phase_len) begin
				offer_item(random_transaction(), CHECK_MODEL, '0);
			end
		end

		// Drain: wait for every owed element, then go on waiting in case the
		// block produces something it should not.
		item_valid <= 1'b0;
		drain = 0;
		while (pending_results.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch("elements never delivered", ELEM_W'(pending_results.size()), '0);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hung handshake; far beyond the slowest correct run.
	initial begin : watchdog
		#(5_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### spiral_matrix_reader.f
+incdir+rtl/core
rtl/core/smr_pkg.sv
rtl/core/spiral_matrix_reader.sv
sim/tb_spiral_matrix_reader.sv
